FILE: src/tsg_pkg.sv
// tsg_pkg: shared constants, types and helpers of the tangent space generator
// used by tsg_div, tsg_sqrt and tangent_space_generator_core; no dependencies
`timescale 1ns / 1ps

package tsg_pkg;

  // vertex store geometry
  localparam int unsigned VERTEX_DEPTH = 1024;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned ADDR_W       = $clog2(VERTEX_DEPTH);

  // item function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // divider: 62-bit dividend, 43-bit divisor, one quotient bit a cycle
  localparam int unsigned DIVD_W     = 62;
  localparam int unsigned DIVS_W     = 43;
  localparam int unsigned DIV_STEPS  = DIVD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // square root: 62-bit radicand, 31-bit root, one root bit a cycle
  localparam int unsigned RAD_W      = 62;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SQRT_CNT_W = $clog2(ROOT_W);

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [19:0] u;
    logic signed [19:0] v;
  } vtx_t;

  typedef logic signed [39:0] sum_t;
  // tangent xyz in elements 0..2, bitangent xyz in 3..5
  typedef logic [5:0][39:0] srow_t;

  localparam sum_t SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam sum_t SUM_MIN = 40'sh80_0000_0000;

  function automatic logic in_range(logic [IDX_W-1:0] idx);
    return (32'(idx) < VERTEX_DEPTH);
  endfunction

  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic signed [40:0] s;
    s = 41'(a) + 41'(b);
    if (s > 41'(SUM_MAX)) return SUM_MAX;
    if (s < 41'(SUM_MIN)) return SUM_MIN;
    return s[39:0];
  endfunction

endpackage

FILE: src/tsg_div.sv
// tsg_div: iterative restoring unsigned divider, one quotient bit per cycle
// depends on tsg_pkg
`timescale 1ns / 1ps

module tsg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsg_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [tsg_pkg::DIVS_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [tsg_pkg::DIVD_W-1:0]  quot_o
);

  logic                           busy_q, done_q;
  logic [tsg_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [tsg_pkg::DIVS_W-1:0]     rem_q, dvs_q;
  logic [tsg_pkg::DIVD_W-1:0]     dvd_q;
  logic [tsg_pkg::DIVS_W:0]       rem_sh, diff;
  logic                           ge;

  assign rem_sh = {rem_q, dvd_q[tsg_pkg::DIVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == tsg_pkg::DIV_CNT_W'(tsg_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[tsg_pkg::DIVS_W-1:0] : rem_sh[tsg_pkg::DIVS_W-1:0];
      dvd_q <= {dvd_q[tsg_pkg::DIVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

FILE: src/tsg_sqrt.sv
// tsg_sqrt: iterative integer square root, one root bit per cycle
// depends on tsg_pkg
`timescale 1ns / 1ps

module tsg_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsg_pkg::RAD_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [tsg_pkg::ROOT_W-1:0]  root_o
);

  logic                            busy_q, done_q;
  logic [tsg_pkg::SQRT_CNT_W-1:0]  cnt_q;
  logic [tsg_pkg::RAD_W-1:0]       rad_q;
  logic [tsg_pkg::ROOT_W-1:0]      root_q;
  logic [tsg_pkg::ROOT_W+1:0]      rem_q;
  logic [tsg_pkg::ROOT_W+3:0]      rem_sh, trial, diff;
  logic                            ge;

  assign rem_sh = {rem_q, rad_q[tsg_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == tsg_pkg::SQRT_CNT_W'(tsg_pkg::ROOT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[tsg_pkg::RAD_W-3:0], 2'b00};
      root_q <= {root_q[tsg_pkg::ROOT_W-2:0], ge};
      rem_q  <= ge ? diff[tsg_pkg::ROOT_W+1:0] : rem_sh[tsg_pkg::ROOT_W+1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: src/tangent_space_generator_core.sv
// tangent_space_generator_core: top level, sequencer, vertex and sum memories
// depends on tsg_pkg, tsg_div, tsg_sqrt
`timescale 1ns / 1ps

// Per-vertex tangent/bitangent generator. A load transfer (func 0) stores one
// vertex and clears its sums in the accepting cycle, so loads stream one per
// clock while the sequencer is idle. A triangle transfer (func 1) and a read
// transfer (func 2) are worked one at a time by a small sequencer around one
// shared 31x31 multiplier, a radix-2 divider and a bit-serial square root;
// in_stall_o is high meanwhile. A triangle takes three vertex reads, the
// determinant, six numerators each followed by one division, then a
// read-modify-write of the sums at each corner. A read of two nonzero sums
// runs six normalizing divisions and two square roots; the normalizing
// shift moves one bit per cycle. A zero sum skips its root and divisions.
// A finished read result sits in the output register until taken, and the
// next item may be accepted meanwhile. Memories need no clearing pass:
// vertices and sums read before their first load are undefined.
module tangent_space_generator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [9:0]          vertex_a_i,
  input  logic [9:0]          vertex_b_i,
  input  logic [9:0]          vertex_c_i,
  input  logic signed [23:0]  pos_x_i,
  input  logic signed [23:0]  pos_y_i,
  input  logic signed [23:0]  pos_z_i,
  input  logic signed [19:0]  tex_u_i,
  input  logic signed [19:0]  tex_v_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [9:0]          vertex_index_o,
  output logic signed [15:0]  tangent_x_o,
  output logic signed [15:0]  tangent_y_o,
  output logic signed [15:0]  tangent_z_o,
  output logic signed [15:0]  bitangent_x_o,
  output logic signed [15:0]  bitangent_y_o,
  output logic signed [15:0]  bitangent_z_o,
  output logic                tangent_zero_o,
  output logic                bitangent_zero_o,
  output logic                degenerate_seen_o
);

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;   // waiting for a transfer
  localparam logic [4:0] ST_TA   = 5'd1;   // vertex a arrives
  localparam logic [4:0] ST_TB   = 5'd2;   // vertex b arrives, first edge
  localparam logic [4:0] ST_TC   = 5'd3;   // vertex c arrives, edge from a to c
  localparam logic [4:0] ST_M0   = 5'd4;   // first product
  localparam logic [4:0] ST_M1   = 5'd5;   // second product
  localparam logic [4:0] ST_M2   = 5'd6;   // difference of products
  localparam logic [4:0] ST_MX   = 5'd7;   // determinant check or divide start
  localparam logic [4:0] ST_DW   = 5'd8;   // waiting on the divider
  localparam logic [4:0] ST_AR   = 5'd9;   // sum read for a corner
  localparam logic [4:0] ST_AW   = 5'd10;  // saturating sum write back
  localparam logic [4:0] ST_RS   = 5'd11;  // sums of the read vertex arrive
  localparam logic [4:0] ST_NL   = 5'd12;  // take magnitudes of one vector
  localparam logic [4:0] ST_NS   = 5'd13;  // normalizing shift, one bit a cycle
  localparam logic [4:0] ST_SQ0  = 5'd14;  // square one component
  localparam logic [4:0] ST_SQ1  = 5'd15;  // accumulate the square
  localparam logic [4:0] ST_RT   = 5'd16;  // square root start
  localparam logic [4:0] ST_RW   = 5'd17;  // waiting on the square root
  localparam logic [4:0] ST_NQ   = 5'd18;  // start one normalizing division
  localparam logic [4:0] ST_FIN  = 5'd19;  // hand the result to the output register

  logic [4:0] state_q, state_d;

  logic in_acc;
  logic out_take;

  // captured item
  logic [1:0]  func_q;
  logic [9:0]  a_q, b_q, c_q;

  // triangle datapath
  tsg_pkg::vtx_t      vtx_in, vrd_q, va_q;
  logic signed [24:0] d1p_q [3];
  logic signed [24:0] d2p_q [3];
  logic signed [20:0] du1_q, dv1_q, du2_q, dv2_q;
  logic               det_ph_q;
  logic [2:0]         comp_q;
  logic [1:0]         ci;
  logic signed [47:0] acc_q;
  logic [47:0]        acc_mag;
  logic [42:0]        detmag_q;
  logic               det_neg_q, num_neg_q;
  tsg_pkg::sum_t      res_q [6];
  tsg_pkg::sum_t      tb_val;
  logic [1:0]         corner_q;
  logic [9:0]         corner_idx;

  // shared multiplier
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod_q;

  // normalization datapath
  logic               vec_q;
  logic [39:0]        m_q [3];
  logic               sgn_q [3];
  logic [39:0]        m_or;
  logic [1:0]         j_q;
  logic [61:0]        sq_q;
  logic [30:0]        n_q;
  logic [15:0]        o_q [6];
  logic [1:0]         z_q;
  logic [2:0]         base;
  logic [15:0]        nq, nval;

  // memories
  tsg_pkg::vtx_t      vmem [tsg_pkg::VERTEX_DEPTH];
  tsg_pkg::srow_t     smem [tsg_pkg::VERTEX_DEPTH];
  logic [tsg_pkg::ADDR_W-1:0] vaddr, sraddr, swaddr;
  logic               vmem_we, smem_we;
  tsg_pkg::srow_t     srd_q, swdata;

  // divider and root unit
  logic                        div_start, div_done;
  logic [tsg_pkg::DIVD_W-1:0]  div_dvd, div_quot;
  logic [tsg_pkg::DIVS_W-1:0]  div_dvs;
  logic                        sqrt_start, sqrt_done;
  logic [tsg_pkg::ROOT_W-1:0]  sqrt_root;

  logic degen_q;
  logic out_valid_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_q & ~out_stall_i;

  assign vtx_in  = {pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i};
  assign acc_mag = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
  assign ci      = (comp_q < 3'd3) ? comp_q[1:0] : 2'(comp_q - 3'd3);
  assign base    = vec_q ? 3'd3 : 3'd0;
  assign m_or    = m_q[0] | m_q[1] | m_q[2];

  always_comb begin
    case (corner_q)
      2'd0:    corner_idx = a_q;
      2'd1:    corner_idx = b_q;
      default: corner_idx = c_q;
    endcase
  end

  // ---------------------------------------------------------------------
  // memories: one write and one registered read port each
  // ---------------------------------------------------------------------
  assign vmem_we = in_acc && (func_i == tsg_pkg::FUNC_LOAD) && tsg_pkg::in_range(vertex_a_i);

  always_comb begin
    unique case (state_q)
      ST_IDLE: vaddr = tsg_pkg::ADDR_W'(vertex_a_i);
      ST_TA:   vaddr = tsg_pkg::ADDR_W'(b_q);
      ST_TB:   vaddr = tsg_pkg::ADDR_W'(c_q);
      default: vaddr = tsg_pkg::ADDR_W'(a_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[tsg_pkg::ADDR_W'(vertex_a_i)] <= vtx_in;
    end
    vrd_q <= vmem[vaddr];
  end

  // sums: cleared by a load, read-modify-written once per triangle corner
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      swdata[i] = tsg_pkg::sat_add($signed(srd_q[i]), res_q[i]);
    end
  end

  assign smem_we = vmem_we || (state_q == ST_AW);
  assign swaddr  = (state_q == ST_AW) ? tsg_pkg::ADDR_W'(corner_idx)
                                      : tsg_pkg::ADDR_W'(vertex_a_i);
  assign sraddr  = (state_q == ST_IDLE) ? tsg_pkg::ADDR_W'(vertex_a_i)
                                        : tsg_pkg::ADDR_W'(corner_idx);

  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      smem[swaddr] <= (state_q == ST_AW) ? swdata : '0;
    end
    srd_q <= smem[sraddr];
  end

  // ---------------------------------------------------------------------
  // shared multiplier, registered product
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if ((state_q == ST_M0) || (state_q == ST_M1)) begin
      if (det_ph_q) begin
        // det = du1*dv2 - dv1*du2
        mul_a = (state_q == ST_M1) ? 31'(dv1_q) : 31'(du1_q);
        mul_b = (state_q == ST_M1) ? 31'(du2_q) : 31'(dv2_q);
      end else if (comp_q < 3'd3) begin
        // tangent numerator dP1*dv2 - dP2*dv1
        mul_a = (state_q == ST_M1) ? 31'(d2p_q[ci]) : 31'(d1p_q[ci]);
        mul_b = (state_q == ST_M1) ? 31'(dv1_q) : 31'(dv2_q);
      end else begin
        // bitangent numerator dP2*du1 - dP1*du2
        mul_a = (state_q == ST_M1) ? 31'(d1p_q[ci]) : 31'(d2p_q[ci]);
        mul_b = (state_q == ST_M1) ? 31'(du2_q) : 31'(du1_q);
      end
    end else if (state_q == ST_SQ0) begin
      mul_a = $signed({1'b0, m_q[j_q][29:0]});
      mul_b = $signed({1'b0, m_q[j_q][29:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------
  // divider and square root
  // ---------------------------------------------------------------------
  assign div_start = ((state_q == ST_MX) && !det_ph_q) || (state_q == ST_NQ);
  assign div_dvd   = (state_q == ST_NQ)
                   ? tsg_pkg::DIVD_W'({m_q[j_q][29:0], 14'd0}) + tsg_pkg::DIVD_W'(n_q[30:1])
                   : {acc_mag[45:0], 16'd0};
  assign div_dvs   = (state_q == ST_NQ) ? tsg_pkg::DIVS_W'(n_q) : detmag_q;

  tsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign sqrt_start = (state_q == ST_RT);

  tsg_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // triangle quotient, saturated to the sum width
  always_comb begin
    if (num_neg_q ^ det_neg_q) begin
      tb_val = (div_quot > 62'h80_0000_0000) ? tsg_pkg::SUM_MIN
                                              : $signed(40'd0 - div_quot[39:0]);
    end else begin
      tb_val = (div_quot > 62'h7F_FFFF_FFFF) ? tsg_pkg::SUM_MAX
                                              : $signed(div_quot[39:0]);
    end
  end

  // normalized component with its sign restored
  assign nq   = div_quot[15:0];
  assign nval = sgn_q[j_q] ? 16'd0 - nq : nq;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_i)
            tsg_pkg::FUNC_TRI: begin
              if (tsg_pkg::in_range(vertex_a_i) && tsg_pkg::in_range(vertex_b_i)
                  && tsg_pkg::in_range(vertex_c_i)) begin
                state_d = ST_TA;
              end
            end
            tsg_pkg::FUNC_READ: begin
              state_d = tsg_pkg::in_range(vertex_a_i) ? ST_RS : ST_FIN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_TA:  state_d = ST_TB;
      ST_TB:  state_d = ST_TC;
      ST_TC:  state_d = ST_M0;
      ST_M0:  state_d = ST_M1;
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_MX;
      ST_MX: begin
        if (det_ph_q) begin
          state_d = (acc_q == '0) ? ST_IDLE : ST_M0;
        end else begin
          state_d = ST_DW;
        end
      end
      ST_DW: begin
        if (div_done) begin
          if (func_q == tsg_pkg::FUNC_READ) begin
            if (j_q == 2'd2) begin
              state_d = vec_q ? ST_FIN : ST_NL;
            end else begin
              state_d = ST_NQ;
            end
          end else begin
            state_d = (comp_q == 3'd5) ? ST_AR : ST_M0;
          end
        end
      end
      ST_AR:  state_d = ST_AW;
      ST_AW:  state_d = (corner_q == 2'd2) ? ST_IDLE : ST_AR;
      ST_RS:  state_d = ST_NL;
      ST_NL:  state_d = ST_NS;
      ST_NS: begin
        if (m_or == '0) begin
          state_d = vec_q ? ST_FIN : ST_NL;
        end else if ((m_or[39:30] == '0) && m_or[29]) begin
          state_d = ST_SQ0;
        end
      end
      ST_SQ0: state_d = ST_SQ1;
      ST_SQ1: state_d = (j_q == 2'd2) ? ST_RT : ST_SQ0;
      ST_RT:  state_d = ST_RW;
      ST_RW:  state_d = sqrt_done ? ST_NQ : ST_RW;
      ST_NQ:  state_d = ST_DW;
      ST_FIN: state_d = (!out_valid_q || !out_stall_i) ? ST_IDLE : ST_FIN;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      degen_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_FIN) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      // zero uv determinant: triangle dropped, flag sticks
      if ((state_q == ST_MX) && det_ph_q && (acc_q == '0)) begin
        degen_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        func_q   <= func_i;
        a_q      <= vertex_a_i;
        b_q      <= vertex_b_i;
        c_q      <= vertex_c_i;
        vec_q    <= 1'b0;
        corner_q <= 2'd0;
        comp_q   <= 3'd0;
        det_ph_q <= 1'b1;
        // out-of-range read answers zero vectors with both flags
        for (int i = 0; i < 6; i++) o_q[i] <= '0;
        z_q <= tsg_pkg::in_range(vertex_a_i) ? 2'b00 : 2'b11;
      end
      ST_TA: va_q <= vrd_q;
      ST_TB: begin
        d1p_q[0] <= 25'(vrd_q.x) - 25'(va_q.x);
        d1p_q[1] <= 25'(vrd_q.y) - 25'(va_q.y);
        d1p_q[2] <= 25'(vrd_q.z) - 25'(va_q.z);
        du1_q    <= 21'(vrd_q.u) - 21'(va_q.u);
        dv1_q    <= 21'(vrd_q.v) - 21'(va_q.v);
      end
      ST_TC: begin
        d2p_q[0] <= 25'(vrd_q.x) - 25'(va_q.x);
        d2p_q[1] <= 25'(vrd_q.y) - 25'(va_q.y);
        d2p_q[2] <= 25'(vrd_q.z) - 25'(va_q.z);
        du2_q    <= 21'(vrd_q.u) - 21'(va_q.u);
        dv2_q    <= 21'(vrd_q.v) - 21'(va_q.v);
      end
      ST_M1: acc_q <= 48'(prod_q);
      ST_M2: acc_q <= acc_q - 48'(prod_q);
      ST_MX: begin
        if (det_ph_q) begin
          detmag_q  <= acc_mag[42:0];
          det_neg_q <= acc_q[47];
          det_ph_q  <= 1'b0;
          comp_q    <= 3'd0;
        end else begin
          num_neg_q <= acc_q[47];
        end
      end
      ST_DW: begin
        if (div_done) begin
          if (func_q == tsg_pkg::FUNC_READ) begin
            o_q[base + 3'(j_q)] <= nval;
            j_q <= j_q + 2'd1;
            if (j_q == 2'd2) vec_q <= 1'b1;
          end else begin
            res_q[comp_q] <= tb_val;
            comp_q        <= comp_q + 3'd1;
          end
        end
      end
      ST_AW: corner_q <= corner_q + 2'd1;
      ST_RS: begin
        for (int i = 0; i < 6; i++) res_q[i] <= $signed(srd_q[i]);
      end
      ST_NL: begin
        for (int i = 0; i < 3; i++) begin
          sgn_q[i] <= res_q[base + 3'(i)][39];
          m_q[i]   <= res_q[base + 3'(i)][39] ? 40'(-res_q[base + 3'(i)])
                                                : 40'(res_q[base + 3'(i)]);
        end
      end
      ST_NS: begin
        if (m_or == '0) begin
          z_q[vec_q] <= 1'b1;
          vec_q      <= 1'b1;
        end else if (m_or[39:30] != '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (!m_or[29]) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end else begin
          j_q  <= 2'd0;
          sq_q <= '0;
        end
      end
      ST_SQ1: begin
        sq_q <= sq_q + 62'(prod_q);
        j_q  <= j_q + 2'd1;
      end
      ST_RW: begin
        if (sqrt_done) begin
          n_q <= sqrt_root;
          j_q <= 2'd0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && (!out_valid_q || !out_stall_i)) begin
      vertex_index_o    <= a_q;
      tangent_x_o       <= $signed(o_q[0]);
      tangent_y_o       <= $signed(o_q[1]);
      tangent_z_o       <= $signed(o_q[2]);
      bitangent_x_o     <= $signed(o_q[3]);
      bitangent_y_o     <= $signed(o_q[4]);
      bitangent_z_o     <= $signed(o_q[5]);
      tangent_zero_o    <= z_q[0];
      bitangent_zero_o  <= z_q[1];
      degenerate_seen_o <= degen_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a result appears only from the hand-off state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside hand-off");

  // zero flag means all three components are zero
  a_tan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tangent_zero_o) |->
      (tangent_x_o == 16'sd0 && tangent_y_o == 16'sd0 && tangent_z_o == 16'sd0))
    else $error("tangent zero flag with nonzero vector");

  // degenerate flag is sticky
  a_degen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    degen_q |=> degen_q)
    else $error("degenerate flag cleared");
`endif

endmodule
